>>> rtl/mpf_pkg.sv
// Shared types and constants of the MQTT PUBLISH framer.
package mpf_pkg;

   // One input item: a header (cmd 0) or one topic or payload byte (cmd 1).
   typedef struct packed {
      logic        cmd;
      logic        dup;
      logic [1:0]  qos;
      logic        retain;
      logic [15:0] packet_id;
      logic [15:0] topic_len;
      logic [27:0] payload_len;
      logic [7:0]  data_byte;
   } req_type;

   // One result item: one byte of the packet stream.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
      logic       error;
   } rsp_type;

   // Kinds of work handed from the front to the back.
   localparam logic [1:0] KIND_HDR  = 2'd0;
   localparam logic [1:0] KIND_DATA = 2'd1;
   localparam logic [1:0] KIND_ERR  = 2'd2;

   // Input command codes.
   localparam logic CMD_HEADER = 1'b0;
   localparam logic CMD_DATA   = 1'b1;

   localparam logic [3:0]  PUBLISH_TYPE     = 4'h3;
   localparam logic [1:0]  QOS_RESERVED     = 2'd3;
   localparam logic [28:0] REM_LEN_MAX      = 29'd268435455;
   localparam logic [28:0] VARINT_LIMIT_1   = 29'd128;
   localparam logic [28:0] VARINT_LIMIT_2   = 29'd16384;
   localparam logic [28:0] VARINT_LIMIT_3   = 29'd2097152;
   localparam logic [28:0] MAX_LEN_RESET    = 29'd268435460;

   // One queue entry: a header to serialize, one data byte, or an error result.
   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  byte_val;   // fixed header byte or data byte
      logic [27:0] rem;        // remaining length
      logic [1:0]  vsz_m1;     // varint size minus one
      logic [15:0] tlen;
      logic [15:0] pid;
      logic        send_pid;   // packet id follows this entry
      logic        last;       // last flag of topic length low byte or data byte
      logic        pid_last;   // last flag of packet id low byte
   } entry_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } q_status_type;

endpackage

>>> rtl/mpf_front.sv
// Front of the framer: length checks, packet tracking and classification of items.
module mpf_front
   import mpf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [28:0] csr_write_data,
   input  logic        take,
   input  req_type     item,
   output logic        push,
   output entry_type   entry
);

   localparam logic [1:0] PH_IDLE    = 2'd0;
   localparam logic [1:0] PH_TOPIC   = 2'd1;
   localparam logic [1:0] PH_PAYLOAD = 2'd2;
   localparam logic [1:0] PH_DROP    = 2'd3;

   logic [1:0]  phase_ff, phase_in;
   logic [15:0] topic_left_ff, topic_left_in;
   logic [27:0] payload_left_ff, payload_left_in;
   logic        need_pid_ff, need_pid_in;
   logic [15:0] pid_ff, pid_in;

   // Limit on the remaining length for each varint size: max_packet_len - 1 - size.
   logic signed [29:0] lim_ff [4];
   logic signed [29:0] lim_in [4];

   logic [28:0] rem;
   logic [1:0]  vsz_m1;
   logic        too_long;
   logic [15:0] tl_dec;
   logic [27:0] pl_dec;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         lim_in[k] = lim_ff[k];
         if (csr_write_enable) begin
            lim_in[k] = $signed({1'b0, csr_write_data}) - 30'(k + 2);
         end
      end
   end

   always_comb begin
      rem = 29'd2 + 29'(item.topic_len) + 29'(item.payload_len)
          + ((item.qos != 2'd0) ? 29'd2 : 29'd0);
      priority if (rem < VARINT_LIMIT_1) begin
         vsz_m1 = 2'd0;
      end else if (rem < VARINT_LIMIT_2) begin
         vsz_m1 = 2'd1;
      end else if (rem < VARINT_LIMIT_3) begin
         vsz_m1 = 2'd2;
      end else begin
         vsz_m1 = 2'd3;
      end
      too_long = (item.qos == QOS_RESERVED) || (rem > REM_LEN_MAX)
               || ($signed({1'b0, rem}) > lim_ff[vsz_m1]);
   end

   assign tl_dec = topic_left_ff - 16'd1;
   assign pl_dec = payload_left_ff - 28'd1;

   always_comb begin
      phase_in        = phase_ff;
      topic_left_in   = topic_left_ff;
      payload_left_in = payload_left_ff;
      need_pid_in     = need_pid_ff;
      pid_in          = pid_ff;
      push            = 1'b0;
      entry.kind      = KIND_DATA;
      entry.byte_val  = item.data_byte;
      entry.rem       = rem[27:0];
      entry.vsz_m1    = vsz_m1;
      entry.tlen      = item.topic_len;
      entry.pid       = pid_ff;
      entry.send_pid  = 1'b0;
      entry.last      = 1'b0;
      entry.pid_last  = 1'b0;
      if (take) begin
         if (item.cmd == CMD_HEADER) begin
            topic_left_in   = item.topic_len;
            payload_left_in = item.payload_len;
            pid_in          = item.packet_id;
            push            = 1'b1;
            if (too_long) begin
               need_pid_in = 1'b0;
               phase_in    = (item.topic_len == 16'd0 && item.payload_len == 28'd0)
                           ? PH_IDLE : PH_DROP;
               entry.kind  = KIND_ERR;
            end else begin
               need_pid_in    = (item.qos != 2'd0);
               entry.kind     = KIND_HDR;
               entry.byte_val = {PUBLISH_TYPE, item.dup, item.qos, item.retain};
               entry.pid      = item.packet_id;
               entry.last     = (item.topic_len == 16'd0) && (item.payload_len == 28'd0)
                              && (item.qos == 2'd0);
               entry.pid_last = (item.payload_len == 28'd0);
               if (item.topic_len == 16'd0) begin
                  // Empty topic: the packet id comes right after the header bytes.
                  entry.send_pid = (item.qos != 2'd0);
                  need_pid_in    = 1'b0;
                  phase_in       = (item.payload_len == 28'd0) ? PH_IDLE : PH_PAYLOAD;
               end else begin
                  phase_in = PH_TOPIC;
               end
            end
         end else begin
            unique case (phase_ff)
               PH_TOPIC: begin
                  push          = 1'b1;
                  topic_left_in = tl_dec;
                  entry.last    = (tl_dec == 16'd0) && (payload_left_ff == 28'd0)
                                && !need_pid_ff;
                  if (tl_dec == 16'd0) begin
                     entry.send_pid = need_pid_ff;
                     entry.pid_last = (payload_left_ff == 28'd0);
                     need_pid_in    = 1'b0;
                     phase_in       = (payload_left_ff == 28'd0) ? PH_IDLE : PH_PAYLOAD;
                  end
               end
               PH_PAYLOAD: begin
                  push            = 1'b1;
                  payload_left_in = pl_dec;
                  entry.last      = (pl_dec == 28'd0);
                  if (pl_dec == 28'd0) begin
                     phase_in = PH_IDLE;
                  end
               end
               PH_DROP: begin
                  if (topic_left_ff != 16'd0) begin
                     topic_left_in = tl_dec;
                  end else if (payload_left_ff != 28'd0) begin
                     payload_left_in = pl_dec;
                  end
                  if (topic_left_in == 16'd0 && payload_left_in == 28'd0) begin
                     phase_in = PH_IDLE;
                  end
               end
               PH_IDLE: begin
                  phase_in = PH_IDLE;
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         topic_left_ff   <= 16'd0;
         payload_left_ff <= 28'd0;
         need_pid_ff     <= 1'b0;
         pid_ff          <= 16'd0;
         for (int k = 0; k < 4; k++) begin
            lim_ff[k] <= $signed({1'b0, MAX_LEN_RESET}) - 30'(k + 2);
         end
      end else begin
         phase_ff        <= phase_in;
         topic_left_ff   <= topic_left_in;
         payload_left_ff <= payload_left_in;
         need_pid_ff     <= need_pid_in;
         pid_ff          <= pid_in;
         for (int k = 0; k < 4; k++) begin
            lim_ff[k] <= lim_in[k];
         end
      end
   end

endmodule

>>> rtl/mpf_queue.sv
// Short work queue between the front and the back of the framer.
module mpf_queue
   import mpf_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  entry_type    push_entry,
   input  logic         pop,
   output q_status_type status,
   output entry_type    head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type          mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_pop;

   assign status.full      = (count_ff == CNT_W'(DEPTH));
   assign status.not_empty = (count_ff != '0);
   assign head             = mem_ff[rd_ptr_ff];
   assign do_pop           = pop && status.not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> rtl/mpf_back.sv
// Back of the framer: expands queue entries into packet bytes behind an output register.
module mpf_back
   import mpf_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      head_valid,
   input  entry_type head,
   output logic      pop,
   output logic      rsp_valid,
   output rsp_type   rsp_item,
   input  logic      rsp_stall
);

   logic [3:0] step_ff, step_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_item_ff, rsp_item_in;

   logic       advance;
   logic       emit;
   logic [3:0] nv;
   logic [3:0] final_step;
   logic [3:0] hdr_tail;
   logic [3:0] dig_idx;
   logic [1:0] tail;
   logic [6:0] digit;
   logic [7:0] tail_byte;
   logic       tail_last;

   assign advance = !rsp_valid_ff || !rsp_stall;
   assign emit    = head_valid && advance;
   assign nv      = {2'b00, head.vsz_m1} + 4'd1;
   assign hdr_tail = step_ff - nv - 4'd1;
   assign dig_idx  = step_ff - 4'd1;

   always_comb begin
      unique case (head.kind)
         KIND_HDR:  final_step = nv + 4'd2 + (head.send_pid ? 4'd2 : 4'd0);
         KIND_DATA: final_step = head.send_pid ? 4'd2 : 4'd0;
         default:   final_step = 4'd0;
      endcase
   end

   always_comb begin
      unique case (dig_idx[1:0])
         2'd0:    digit = head.rem[6:0];
         2'd1:    digit = head.rem[13:7];
         2'd2:    digit = head.rem[20:14];
         default: digit = head.rem[27:21];
      endcase
   end

   // Tail bytes: topic length high and low, then packet id high and low.
   always_comb begin
      tail = (head.kind == KIND_HDR) ? hdr_tail[1:0] : 2'(step_ff[1:0] + 2'd1);
      unique case (tail)
         2'd0: begin
            tail_byte = head.tlen[15:8];
            tail_last = 1'b0;
         end
         2'd1: begin
            tail_byte = head.tlen[7:0];
            tail_last = head.last;
         end
         2'd2: begin
            tail_byte = head.pid[15:8];
            tail_last = 1'b0;
         end
         default: begin
            tail_byte = head.pid[7:0];
            tail_last = head.pid_last;
         end
      endcase
   end

   always_comb begin
      rsp_item_in.error = 1'b0;
      unique case (head.kind)
         KIND_HDR: begin
            priority if (step_ff == 4'd0) begin
               rsp_item_in.out_byte = head.byte_val;
               rsp_item_in.last     = 1'b0;
            end else if (step_ff <= nv) begin
               rsp_item_in.out_byte = {(dig_idx[1:0] != head.vsz_m1), digit};
               rsp_item_in.last     = 1'b0;
            end else begin
               rsp_item_in.out_byte = tail_byte;
               rsp_item_in.last     = tail_last;
            end
         end
         KIND_DATA: begin
            if (step_ff == 4'd0) begin
               rsp_item_in.out_byte = head.byte_val;
               rsp_item_in.last     = head.last;
            end else begin
               rsp_item_in.out_byte = tail_byte;
               rsp_item_in.last     = tail_last;
            end
         end
         default: begin
            rsp_item_in.out_byte = 8'd0;
            rsp_item_in.last     = 1'b1;
            rsp_item_in.error    = 1'b1;
         end
      endcase
   end

   assign pop = emit && (step_ff == final_step);

   always_comb begin
      step_in = step_ff;
      if (pop) begin
         step_in = 4'd0;
      end else if (emit) begin
         step_in = step_ff + 4'd1;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = emit;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

>>> rtl/mqtt_publish_framer.sv
// Top level of the MQTT 3.1.1 PUBLISH packet framer.
//
// This block turns a header transfer and the topic and payload byte transfers that
// follow it into a serialized PUBLISH packet, one byte per result transfer: the fixed
// header byte, the remaining length as a 1 to 4 byte varint, the big-endian topic
// length, the topic bytes, the packet id when qos is above zero, and the payload,
// with last set on the final byte. A packet whose remaining length exceeds 268435455,
// whose whole length exceeds max_packet_len, or whose qos is 3 yields one result with
// out_byte 0, last 1 and error 1, and its data bytes are swallowed. Data bytes pass
// through at one per cycle unless the receiver stalls or the serializer is busy, via
// the queue and then the output register. A header transfer yields 4 to 9 bytes
// (1 + varint size + 2, plus 2 when the packet id follows), a refused header only its
// error byte, and the data byte that ends the topic 3 bytes when the packet id
// follows it; the front keeps accepting input while a queue of DEPTH entries has room,
// so these bursts overlap with incoming data. max_packet_len is written through
// csr_write_enable and csr_write_data; the user must do so only while the block is
// idle, which the block does not enforce; it takes effect for the very next transfer.
module mqtt_publish_framer
   import mpf_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [28:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_item,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_item
);

   q_status_type q_status;
   entry_type    push_entry;
   entry_type    head;
   logic         push;
   logic         pop;
   logic         req_accept;

   // The front is held off only when the queue has no free entry.
   assign req_stall  = q_status.full;
   assign req_accept = req_valid && !req_stall;

   mpf_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .take             (req_accept),
      .item             (req_item),
      .push             (push),
      .entry            (push_entry)
   );

   mpf_queue #(
      .DEPTH (DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .status     (q_status),
      .head       (head)
   );

   mpf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_status.not_empty),
      .head       (head),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_item   (rsp_item),
      .rsp_stall  (rsp_stall)
   );

   // The back only retires an entry that the queue actually holds.
   assert property (@(posedge clock) disable iff (reset) pop |-> q_status.not_empty)
      else $error("serializer retired an entry from an empty queue");

   // Work enters the queue only on an accepted transfer, never while it is full.
   assert property (@(posedge clock) disable iff (reset) push |-> req_accept)
      else $error("queue written without an accepted input transfer");

   // An error result is always a lone zero byte that closes the packet.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.error) |-> (rsp_item.last && rsp_item.out_byte == 8'd0))
      else $error("error result without last or with a nonzero byte");

endmodule

>>> bench/tb_mqtt_publish_framer.sv
// Self-checking testbench for the MQTT PUBLISH framer: directed, stall and random traffic.
`timescale 1ns / 1ps

module tb_mqtt_publish_framer;
   import mpf_pkg::*;

   // The slowest correct run stays far below this; hitting it means the block hung.
   localparam int CYCLE_LIMIT = 400000;
   // Cycles allowed after the last expected byte before a register write or the end.
   // Dropped data bytes produce no result, and a header can keep the serializer busy
   // emitting up to nine bytes per queue entry.
   localparam int SETTLE_CYCLES = 40;

   // Phases of the framing state, tracked by the predictor alongside the block.
   typedef enum logic [1:0] {
      FRAME_IDLE,
      FRAME_TOPIC,
      FRAME_PAYLOAD,
      FRAME_DROP
   } frame_phase_type;

   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [28:0] csr_write_data   = '0;
   logic        req_valid        = 1'b0;
   logic        req_stall;
   req_type     req_item         = '0;
   logic        rsp_valid;
   logic        rsp_stall        = 1'b0;
   rsp_type     rsp_item;

   // Predictor state: a private copy of the framing state and of the length limit.
   frame_phase_type frame_phase = FRAME_IDLE;
   logic [15:0]  topic_left     = '0;
   logic [27:0]  payload_left   = '0;
   logic         pid_pending    = 1'b0;
   logic [15:0]  held_pid       = '0;
   logic [28:0]  max_len_limit  = MAX_LEN_RESET;

   // Packet bytes the block owes us, oldest first.
   rsp_type expected_bytes[$];

   int idle_pct       = 0;   // chance in a hundred that the sender idles a cycle
   int stall_pct      = 0;   // chance in a hundred that the receiver stalls a cycle
   int hold_left      = 0;   // cycles left in a forced receiver hold-off
   int items_counted  = 0;   // transfers that do real work in the block
   int mismatch_count = 0;
   int cycle_count    = 0;

   mqtt_publish_framer dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_item         (req_item),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_item         (rsp_item)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------

   function automatic void push_byte(input logic [7:0] value, input logic last,
                                     input logic error);
      rsp_type r;
      r.out_byte = value;
      r.last     = last;
      r.error    = error;
      expected_bytes.push_back(r);
   endfunction

   // The topic is done: the packet id goes out when the qos asks for it, and the
   // packet either continues with its payload or is complete.
   function automatic void close_topic();
      if (pid_pending) begin
         push_byte(held_pid[15:8], 1'b0, 1'b0);
         push_byte(held_pid[7:0], payload_left == 0, 1'b0);
         pid_pending = 1'b0;
      end
      frame_phase = (payload_left == 0) ? FRAME_IDLE : FRAME_PAYLOAD;
   endfunction

   // Works out the packet bytes that one accepted transfer produces.
   function automatic void frame_transfer(input req_type it);
      logic [31:0] rem_len;
      logic [31:0] whole_len;
      logic [31:0] rest;
      int          varint_size;
      if (it.cmd == CMD_HEADER) begin
         // A header always starts over, abandoning whatever packet was open.
         rem_len = 32'd2 + it.topic_len + it.payload_len
                 + ((it.qos != 0) ? 32'd2 : 32'd0);
         varint_size = (rem_len < VARINT_LIMIT_1) ? 1 :
                       (rem_len < VARINT_LIMIT_2) ? 2 :
                       (rem_len < VARINT_LIMIT_3) ? 3 : 4;
         whole_len = 32'd1 + rem_len + 32'(varint_size);
         topic_left   = it.topic_len;
         payload_left = it.payload_len;
         held_pid     = it.packet_id;
         if (it.qos == QOS_RESERVED || rem_len > REM_LEN_MAX
             || whole_len > max_len_limit) begin
            // Refused: one error byte, then the announced data bytes are swallowed.
            pid_pending = 1'b0;
            frame_phase = (it.topic_len == 0 && it.payload_len == 0)
                        ? FRAME_IDLE : FRAME_DROP;
            push_byte(8'h00, 1'b1, 1'b1);
            return;
         end
         pid_pending = (it.qos != 0);
         push_byte({PUBLISH_TYPE, it.dup, it.qos, it.retain}, 1'b0, 1'b0);
         rest = rem_len;
         for (int i = 0; i < varint_size; i++) begin
            push_byte({(rest >> 7) != 0, rest[6:0]}, 1'b0, 1'b0);
            rest = rest >> 7;
         end
         push_byte(it.topic_len[15:8], 1'b0, 1'b0);
         push_byte(it.topic_len[7:0],
                   it.topic_len == 0 && it.payload_len == 0 && !pid_pending, 1'b0);
         if (it.topic_len == 0) begin
            close_topic();
         end else begin
            frame_phase = FRAME_TOPIC;
         end
      end else begin
         case (frame_phase)
            FRAME_TOPIC: begin
               topic_left = topic_left - 1'b1;
               push_byte(it.data_byte,
                         topic_left == 0 && payload_left == 0 && !pid_pending, 1'b0);
               if (topic_left == 0) begin
                  close_topic();
               end
            end
            FRAME_PAYLOAD: begin
               payload_left = payload_left - 1'b1;
               push_byte(it.data_byte, payload_left == 0, 1'b0);
               if (payload_left == 0) begin
                  frame_phase = FRAME_IDLE;
               end
            end
            FRAME_DROP: begin
               if (topic_left > 0) begin
                  topic_left = topic_left - 1'b1;
               end else if (payload_left > 0) begin
                  payload_left = payload_left - 1'b1;
               end
               if (topic_left == 0 && payload_left == 0) begin
                  frame_phase = FRAME_IDLE;
               end
            end
            default: ;   // A data byte with no open packet is ignored.
         endcase
      end
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   // Unused fields carry random values so that every input bit toggles.
   function automatic req_type header_item(input logic dup, input logic [1:0] qos,
                                           input logic retain, input logic [15:0] pid,
                                           input logic [15:0] tlen, input logic [27:0] plen);
      req_type it;
      it.cmd         = CMD_HEADER;
      it.dup         = dup;
      it.qos         = qos;
      it.retain      = retain;
      it.packet_id   = pid;
      it.topic_len   = tlen;
      it.payload_len = plen;
      it.data_byte   = 8'($urandom);
      return it;
   endfunction

   function automatic req_type data_item(input logic [7:0] value);
      req_type it;
      it.cmd         = CMD_DATA;
      it.dup         = 1'($urandom);
      it.qos         = 2'($urandom);
      it.retain      = 1'($urandom);
      it.packet_id   = 16'($urandom);
      it.topic_len   = 16'($urandom);
      it.payload_len = 28'($urandom);
      it.data_byte   = value;
      return it;
   endfunction

   // Offers one transfer and returns once it is accepted, possibly followed by a
   // random idle gap. Called right after a rising edge. When no gap is taken, valid
   // stays high and the next call only replaces the payload.
   task automatic send_item(input req_type it);
      int gap;
      gap = 0;
      req_valid <= 1'b1;
      req_item  <= it;
      do @(posedge clock); while (req_stall);
      if (it.cmd == CMD_HEADER || frame_phase == FRAME_TOPIC
          || frame_phase == FRAME_PAYLOAD) begin
         items_counted++;
      end
      frame_transfer(it);
      while (gap < 40 && $urandom_range(99) < idle_pct) begin
         gap++;
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // A header followed by exactly the data bytes it announces.
   task automatic send_packet(input logic dup, input logic [1:0] qos, input logic retain,
                              input logic [15:0] pid, input logic [15:0] tlen,
                              input logic [27:0] plen);
      send_item(header_item(dup, qos, retain, pid, tlen, plen));
      repeat (int'(tlen) + int'(plen)) send_item(data_item(8'($urandom)));
   endtask

   // Stops offering input and waits until every expected byte has come out, then
   // lets the block settle so that swallowed bytes are also worked off.
   task automatic wait_until_drained();
      req_valid <= 1'b0;
      while (expected_bytes.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Changes the length limit with the block idle. An open packet is closed first
   // with an empty header, which always leaves the framer with nothing pending.
   task automatic write_max_packet_len(input logic [28:0] value);
      if (frame_phase != FRAME_IDLE) begin
         send_item(header_item(1'($urandom), 2'd0, 1'($urandom), 16'($urandom),
                               16'd0, 28'd0));
      end
      wait_until_drained();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      max_len_limit = value;
      csr_write_enable <= 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Varint size thresholds and the remaining length ceiling, all under the reset
   // limit. Each header is cut off by the next one, so no long payload is needed;
   // the bytes that matter are all produced by the header itself.
   task automatic test_length_boundaries();
      send_item(header_item(1'b0, 2'd0, 1'b0, 16'h0000, 16'd0, 28'd125));       // 127
      send_item(header_item(1'b1, 2'd1, 1'b1, 16'h1234, 16'd2, 28'd122));       // 128
      send_item(header_item(1'b0, 2'd2, 1'b0, 16'hFFFF, 16'd0, 28'd16379));     // 16383
      send_item(header_item(1'b1, 2'd0, 1'b0, 16'h0001, 16'd100, 28'd16282));   // 16384
      send_item(data_item(8'h00));
      send_item(data_item(8'hFF));
      send_item(header_item(1'b0, 2'd0, 1'b1, 16'h8000, 16'd0, 28'd2097149));   // 2097151
      // Largest topic length, and the first four-byte varint.
      send_item(header_item(1'b0, 2'd1, 1'b0, 16'h00FF, 16'hFFFF, 28'd2031613));
      send_item(data_item(8'h5A));
      // Remaining length 268435455 makes the whole packet exactly the reset limit.
      send_item(header_item(1'b0, 2'd0, 1'b0, 16'h0000, 16'd0, 28'd268435453));
      send_item(data_item(8'hA5));
      // Largest payload length: the remaining length overflows and is refused.
      send_item(header_item(1'b1, 2'd2, 1'b1, 16'hFFFF, 16'd0, 28'hFFFFFFF));
      send_item(data_item(8'h11));
      // An empty qos 1 packet ends on the low packet id byte.
      send_packet(1'b0, 2'd1, 1'b0, 16'hFFFF, 16'd0, 28'd0);
   endtask

   // Every qos level and flag, empty packets, stray data bytes and abandoned packets.
   task automatic test_flags_and_special_cases();
      send_item(data_item(8'h42));                              // nothing open: ignored
      send_packet(1'b1, 2'd0, 1'b1, 16'hFFFF, 16'd0, 28'd0);    // ends on topic length
      send_packet(1'b0, 2'd1, 1'b0, 16'h0000, 16'd2, 28'd2);
      send_packet(1'b1, 2'd2, 1'b0, 16'hA55A, 16'd1, 28'd0);    // ends on packet id
      send_packet(1'b0, QOS_RESERVED, 1'b1, 16'h0F0F, 16'd2, 28'd1);  // refused, swallowed
      send_item(data_item(8'h99));                              // idle again: ignored
      // A header arriving mid-topic abandons the open packet without a last marker.
      send_item(header_item(1'b0, 2'd0, 1'b0, 16'h0000, 16'd3, 28'd3));
      send_item(data_item(8'h01));
      send_item(data_item(8'h02));
      send_packet(1'b1, 2'd2, 1'b1, 16'h7E81, 16'd1, 28'd3);
   endtask

   // Length limit at zero, at an exact fit, one byte short, and back at reset.
   task automatic test_length_limit();
      write_max_packet_len(29'd0);
      send_packet(1'b0, 2'd0, 1'b0, 16'h1111, 16'd1, 28'd1);    // every packet refused
      write_max_packet_len(29'd8);
      send_packet(1'b0, 2'd0, 1'b0, 16'h2222, 16'd1, 28'd2);    // whole length 7
      send_packet(1'b1, 2'd1, 1'b1, 16'h3333, 16'd1, 28'd1);    // whole length 8, fits
      send_packet(1'b0, 2'd1, 1'b0, 16'h4444, 16'd1, 28'd2);    // whole length 9, refused
      write_max_packet_len(MAX_LEN_RESET);
      send_packet(1'b0, 2'd2, 1'b0, 16'h5555, 16'd2, 28'd2);
   endtask

   // The receiver holds off for a long stretch while the sender keeps offering a
   // long packet, so the internal queue fills and the input transfer stalls.
   task automatic test_receiver_hold_off();
      idle_pct  = 0;
      stall_pct = 0;
      hold_left <= 300;
      send_packet(1'($urandom), 2'd1, 1'($urandom), 16'($urandom), 16'd4, 28'd40);
      send_packet(1'($urandom), 2'd0, 1'($urandom), 16'($urandom), 16'd3, 28'd6);
   endtask

   // Mostly complete packets with random content and small sizes; the rest are
   // headers with wide random lengths cut short, and stray data bytes.
   task automatic run_random_traffic(input int count);
      int         goal;
      int         kind;
      logic [1:0] qos;
      goal = items_counted + count;
      while (items_counted < goal) begin
         kind = $urandom_range(99);
         qos  = ($urandom_range(15) == 0) ? QOS_RESERVED : 2'($urandom_range(2));
         if (kind < 75) begin
            send_packet(1'($urandom), qos, 1'($urandom), 16'($urandom),
                        16'($urandom_range(6)), 28'($urandom_range(10)));
         end else if (kind < 90) begin
            send_item(header_item(1'($urandom), qos, 1'($urandom), 16'($urandom),
                                  16'($urandom), 28'($urandom)));
            repeat ($urandom_range(3)) send_item(data_item(8'($urandom)));
         end else begin
            repeat ($urandom_range(1, 3)) send_item(data_item(8'($urandom)));
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Receiver side
   // ------------------------------------------------------------------------

   // Random stalls, plus a forced stretch whenever a hold-off is running.
   always @(posedge clock) begin
      rsp_stall <= !reset && (hold_left != 0 || $urandom_range(99) < stall_pct);
   end

   // Counts down a requested hold-off; a test loads it only while it is zero.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Every result transfer is matched against the oldest expected byte.
   always @(posedge clock) begin
      rsp_type want;
      logic    unexpected;
      if (!reset && rsp_valid && !rsp_stall) begin
         unexpected = (expected_bytes.size() == 0);
         want = unexpected ? rsp_type'('0) : expected_bytes.pop_front();
         if (unexpected || want.out_byte !== rsp_item.out_byte
             || want.last !== rsp_item.last || want.error !== rsp_item.error) begin
            if (mismatch_count < 10) begin
               $display("Mismatch at cycle %0d%s: expected byte %02h last %b error %b,",
                        cycle_count, unexpected ? " (no byte expected)" : "",
                        want.out_byte, want.last, want.error);
               $display("   got byte %02h last %b error %b",
                        rsp_item.out_byte, rsp_item.last, rsp_item.error);
            end
            mismatch_count++;
         end
      end
   end

   // Watchdog against a hung handshake.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed checks run with a little idling on both sides.
      idle_pct  = 20;
      stall_pct = 20;
      test_length_boundaries();
      test_flags_and_special_cases();
      test_length_limit();
      test_receiver_hold_off();

      // Random traffic under each idling pattern and a different length limit.
      write_max_packet_len(MAX_LEN_RESET);
      idle_pct  = 0;
      stall_pct = 0;
      run_random_traffic(50);

      write_max_packet_len(29'd14);
      idle_pct  = 65;
      stall_pct = 0;
      run_random_traffic(50);

      write_max_packet_len(29'($urandom_range(MAX_LEN_RESET)));
      idle_pct  = 0;
      stall_pct = 65;
      run_random_traffic(50);

      write_max_packet_len(29'd20);
      idle_pct  = 27;
      stall_pct = 27;
      run_random_traffic(50);

      wait_until_drained();
      if (mismatch_count == 0 && expected_bytes.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
